### src/htfv_pkg.sv
// package: constants and helpers for the hashed term-frequency vector
package htfv_pkg;
    localparam int unsigned BUCKETS_DEF    = 64;
    localparam int unsigned COUNT_BITS_DEF = 20;
    localparam logic [31:0] FNV_BASIS      = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME      = 32'd16777619;
    localparam logic [14:0] SCALE          = 15'd32767;
    localparam int unsigned WEIGHT_BITS    = 15;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd90) ||
               (b >= 8'd97 && b <= 8'd122);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
    endfunction

    // result item handed from the drain to the output register
    typedef struct packed {
        logic [5:0]  bucket_index;
        logic [14:0] weight;
        logic        last_entry;
        logic        empty_text;
    } t_result;
endpackage

### src/htfv_divider.sv
// divider: restoring divide, one quotient bit per cycle
module htfv_divider #(
    parameter int unsigned COUNT_BITS = htfv_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS+14:0] i_dividend,
    input  logic [COUNT_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [14:0]           o_quotient
);
    import htfv_pkg::*;
    localparam int unsigned NB = COUNT_BITS + 15;
    localparam int unsigned CB = $clog2(NB + 1);

    logic [NB-1:0]       r_quo;
    logic [COUNT_BITS:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [CB-1:0]       r_cnt;
    logic                r_busy;
    logic [COUNT_BITS:0] w_shift;
    logic [COUNT_BITS:0] w_sub;

    assign w_shift = {r_rem[COUNT_BITS-1:0], r_quo[NB-1]};
    assign w_sub   = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(NB);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!w_sub[COUNT_BITS]) begin
                    r_rem <= w_sub;
                    r_quo <= {r_quo[NB-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[NB-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // count never exceeds the total, so the quotient fits in 15 bits
    assign o_quotient = r_quo[WEIGHT_BITS-1:0];
endmodule

### src/hashed_term_frequency_vector.sv
// top level: tokenizer, hashed bucket counter memory and drain
// Takes one text byte per cycle with no stall while a text streams in. Tokens
// are runs of ASCII letters and digits, lower-cased and hashed with 32-bit
// FNV-1a; each closed token bumps the counter of bucket (hash mod BUCKETS) and
// a token total, both saturating. The counters sit in a memory with one read
// and one write port and are updated by read-modify-write, forwarded when
// consecutive tokens land in the same bucket. A byte flagged tlast closes any
// open token and starts the drain, during which s_axis_tready is low: every
// bucket is read and cleared, a nonzero one is divided by the token total in
// a bit-serial divider, and nonzero weights leave in ascending bucket order.
// One result is held back so that tlast can mark the final one; a text
// without any nonzero weight gives a single result with tuser set. The drain
// also stalls while a finished result waits on m_axis_tready. After reset a
// clearing pass zeroes the memory before the first byte is taken.
// s_axis_tdata: [7:0] text_byte. s_axis_tlast: last_byte.
// m_axis_tdata: [5:0] bucket_index, [20:6] weight, zero-filled to 24 bits.
// m_axis_tlast: last_entry. m_axis_tuser: empty_text.
module hashed_term_frequency_vector #(
    parameter int unsigned BUCKETS    = htfv_pkg::BUCKETS_DEF,
    parameter int unsigned COUNT_BITS = htfv_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [5:0] bucket_index, [20:6] weight
    output logic        m_axis_tlast,   // last_entry
    output logic        m_axis_tuser    // empty_text
);
    import htfv_pkg::*;
    localparam int unsigned AB = (BUCKETS > 2) ? $clog2(BUCKETS) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    // weights of the hash bytes modulo the bucket count
    localparam int unsigned K1 = 256 % BUCKETS;
    localparam int unsigned K2 = 65536 % BUCKETS;
    localparam int unsigned K3 = 16777216 % BUCKETS;

    typedef enum logic [6:0] {
        S_CLR   = 7'b0000001,
        S_RUN   = 7'b0000010,
        S_READ  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [COUNT_BITS-1:0] r_mem [BUCKETS];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [31:0] r_hash;
    logic        r_inside;
    logic [COUNT_BITS-1:0] r_total;
    // pending increment stage: read issued last cycle
    logic        r_inc_v;
    logic [AB-1:0] r_inc_a;
    logic [AB-1:0] r_scan;
    logic [14:0] r_quot;         // weight of the bucket just scanned, zero if none
    logic        r_held_v;       // a result waits for the next one to know tlast
    t_result     r_held;
    logic        r_out_v;
    t_result     r_out;
    logic        w_div_go;
    logic [COUNT_BITS+14:0] w_dividend;
    logic        w_div_done;
    logic [14:0] w_quo;

    logic        w_acc, w_alnum, w_close, w_last;
    logic [31:0] w_hash_mix;
    logic [31:0] w_close_hash;
    logic [AB-1:0] w_mod0 [256];
    logic [AB-1:0] w_mod1 [256];
    logic [AB-1:0] w_mod2 [256];
    logic [AB-1:0] w_mod3 [256];
    logic [7:0]  w_sum;
    logic [AB-1:0] w_idx;
    logic [COUNT_BITS-1:0] w_cur;
    logic        w_out_free;
    logic        w_out_load;
    t_result     n_out;

    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_alnum    = is_alnum(s_axis_tdata);
    assign w_hash_mix = (r_hash ^ {24'd0, fold_case(s_axis_tdata)}) * FNV_PRIME;
    assign w_close    = w_acc && r_inside && (!w_alnum || s_axis_tlast) ||
                        w_acc && w_alnum && s_axis_tlast;
    assign w_last     = w_acc && s_axis_tlast;
    // closing hash: with alnum last byte include it
    assign w_close_hash = w_alnum ? w_hash_mix : r_hash;

    // residue tables: each hash byte reduced by its weight, then the sum reduced
    for (genvar v = 0; v < 256; v++) begin : g_mod
        assign w_mod0[v] = AB'(v % BUCKETS);
        assign w_mod1[v] = AB'((v * K1) % BUCKETS);
        assign w_mod2[v] = AB'((v * K2) % BUCKETS);
        assign w_mod3[v] = AB'((v * K3) % BUCKETS);
    end
    assign w_sum = 8'(w_mod0[w_close_hash[7:0]]) + 8'(w_mod1[w_close_hash[15:8]]) +
                   8'(w_mod2[w_close_hash[23:16]]) + 8'(w_mod3[w_close_hash[31:24]]);
    assign w_idx = w_mod0[w_sum];

    // current count from the read register, which already holds any forwarded write
    assign w_cur = r_rdata;
    assign w_out_free = !r_out_v || m_axis_tready;
    assign s_axis_tready = (r_state == S_RUN);
    assign w_dividend = {15'd0, r_rdata} * {{(COUNT_BITS){1'b0}}, SCALE};
    // divider picks up the count while it still sits in the read register
    assign w_div_go = (r_state == S_CHECK) && (r_rdata != '0) && (r_total != '0);

    htfv_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_go),
        .i_dividend(w_dividend),
        .i_divisor (r_total),
        .o_done    (w_div_done),
        .o_quotient(w_quo)
    );

    // memory: one read port, one write port
    logic          w_we;
    logic [AB-1:0] w_wa, w_ra;
    logic [COUNT_BITS-1:0] w_wd;
    logic          w_fwd;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_inc_a;
        w_wd = (w_cur == CMAX) ? w_cur : w_cur + 1'b1;
        w_ra = w_idx;
        if (r_inc_v) begin
            // last increment of a text may land in the first drain cycle
            w_we = 1'b1;
        end else if (r_state == S_CHECK || r_state == S_CLR) begin
            w_we = 1'b1;
            w_wa = r_scan;
            w_wd = '0;
        end
        if (r_state != S_RUN) w_ra = r_scan;
    end
    assign w_fwd = w_we && (w_wa == w_ra);

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rdata <= w_fwd ? w_wd : r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_hash   <= FNV_BASIS;
            r_inside <= 1'b0;
            r_total  <= '0;
            r_inc_v  <= 1'b0;
            r_scan   <= '0;
            r_held_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    // zero one entry per cycle after reset
                    if (r_scan == AB'(BUCKETS - 1)) begin
                        r_scan  <= '0;
                        r_state <= S_RUN;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_RUN: begin
                    r_inc_v <= w_close;
                    r_inc_a <= w_idx;
                    if (w_acc) begin
                        if (w_alnum && !s_axis_tlast) begin
                            r_hash   <= w_hash_mix;
                            r_inside <= 1'b1;
                        end else begin
                            r_hash   <= FNV_BASIS;
                            r_inside <= 1'b0;
                        end
                        if (w_close && r_total != CMAX) r_total <= r_total + 1'b1;
                    end
                    if (w_last) begin
                        r_state <= S_READ;
                        r_scan  <= '0;
                    end
                end
                S_READ: begin
                    // finishes pending increment, read of r_scan issued
                    r_inc_v <= 1'b0;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_rdata != '0 && r_total != '0) begin
                        r_state <= S_DIV;
                    end else begin
                        r_quot  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_quot  <= w_quo;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // a new weight pushes the held one out, so wait for room
                    if (r_quot == '0 || !r_held_v || w_out_free) begin
                        if (r_quot != '0) begin
                            r_held_v <= 1'b1;
                            r_held   <= '{bucket_index: 6'(r_scan), weight: r_quot,
                                          last_entry: 1'b0, empty_text: 1'b0};
                        end
                        if (r_scan == AB'(BUCKETS - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_scan  <= r_scan + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_held_v <= 1'b0;
                        r_total  <= '0;
                        r_state  <= S_RUN;
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    // output register: loaded by the drain, emptied by the receiver
    always_comb begin
        w_out_load = 1'b0;
        n_out      = r_held;
        if (r_state == S_EMIT && r_quot != '0 && r_held_v && w_out_free) begin
            w_out_load = 1'b1;
        end
        if (r_state == S_FIN && w_out_free) begin
            w_out_load = 1'b1;
            n_out      = r_held_v ? '{bucket_index: r_held.bucket_index,
                                      weight: r_held.weight, last_entry: 1'b1,
                                      empty_text: 1'b0}
                                  : '{bucket_index: 6'd0, weight: 15'd0,
                                      last_entry: 1'b1, empty_text: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
            r_out   <= n_out;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {3'd0, r_out.weight, r_out.bucket_index};
    assign m_axis_tlast  = r_out.last_entry;
    assign m_axis_tuser  = r_out.empty_text;
endmodule

### src/htfv_checker.sv
// checker: port-level properties of the hashed term-frequency vector
module htfv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 24'd0)
        else $error("empty result malformed");
    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[20:6] != 15'd0)
        else $error("zero weight emitted");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken mid-drain");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after the last byte");
endmodule

bind hashed_term_frequency_vector htfv_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
);

### bench/hashed_term_frequency_vector_tb.sv
// testbench for the hashed term-frequency vector: byte stream in, bucket weights out
`timescale 1ns / 1ps

module hashed_term_frequency_vector_tb;
    import htfv_pkg::*;

    localparam int unsigned NBUCKETS  = BUCKETS_DEF;
    localparam int unsigned CNT_BITS  = COUNT_BITS_DEF;
    localparam logic [31:0] CNT_MAX   = (32'd1 << CNT_BITS) - 32'd1;
    localparam int          IDLE_LIMIT = 20000;

    // one expected or observed result item
    typedef struct packed {
        logic [5:0]  bucket_index;
        logic [14:0] weight;
        logic        last_entry;
        logic        empty_text;
    } t_entry;

    // tokenizer and bucket counters mirrored in the bench, plus the expected entry queue
    class tf_scoreboard;
        logic [31:0] hash;
        logic        in_token;
        logic [31:0] total;
        logic [31:0] counts [NBUCKETS];
        t_entry      pending [$];
        int          mismatches;
        int          entries_seen;
        int          texts_done;
        int          empty_seen;

        function new();
            mismatches = 0;
            entries_seen = 0;
            texts_done = 0;
            empty_seen = 0;
            clear_text();
        endfunction

        function void clear_text();
            hash = FNV_BASIS;
            in_token = 1'b0;
            total = 0;
            foreach (counts[i]) counts[i] = 0;
        endfunction

        function void count_token();
            int idx;
            if (!in_token) return;
            idx = hash % NBUCKETS;
            if (counts[idx] < CNT_MAX) counts[idx]++;
            if (total < CNT_MAX) total++;
            hash = FNV_BASIS;
            in_token = 1'b0;
        endfunction

        // note one accepted text byte and queue the entries it yields
        function void note_byte(logic [7:0] b, logic last);
            logic [63:0] w;
            logic [7:0]  lc;
            t_entry      e;
            int          final_idx;
            if ((b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd90) ||
                (b >= 8'd97 && b <= 8'd122)) begin
                lc = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
                hash = (hash ^ {24'd0, lc}) * 32'd16777619;
                in_token = 1'b1;
            end else begin
                count_token();
            end
            if (!last) return;
            count_token();
            texts_done++;
            final_idx = -1;
            for (int i = 0; i < NBUCKETS; i++) begin
                w = (total == 0) ? 0 : (64'(counts[i]) * 64'd32767) / total;
                if (counts[i] != 0 && w != 0) final_idx = i;
            end
            if (final_idx < 0) begin
                e = '{bucket_index: 6'd0, weight: 15'd0, last_entry: 1'b1,
                      empty_text: 1'b1};
                pending = {pending, e};
            end else begin
                for (int i = 0; i <= final_idx; i++) begin
                    w = (total == 0) ? 0 : (64'(counts[i]) * 64'd32767) / total;
                    if (counts[i] == 0 || w == 0) continue;
                    e.bucket_index = i[5:0];
                    e.weight       = w[14:0];
                    e.last_entry   = (i == final_idx);
                    e.empty_text   = 1'b0;
                    pending = {pending, e};
                end
            end
            clear_text();
        endfunction

        // compare one accepted result item with the oldest expectation
        function void check_entry(t_entry got);
            t_entry exp_e;
            entries_seen++;
            if (got.empty_text) empty_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected entry: idx=%0d w=%0d last=%0b empty=%0b",
                             got.bucket_index, got.weight, got.last_entry, got.empty_text);
                return;
            end
            exp_e = pending.pop_front();
            if (got !== exp_e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"entry mismatch: exp idx=%0d w=%0d last=%0b empty=%0b, ",
                              "got idx=%0d w=%0d last=%0b empty=%0b"},
                             exp_e.bucket_index, exp_e.weight, exp_e.last_entry,
                             exp_e.empty_text, got.bucket_index, got.weight,
                             got.last_entry, got.empty_text);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] text_byte
    logic        s_axis_tlast;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [5:0] bucket_index, [20:6] weight
    logic        m_axis_tlast;    // last_entry
    logic        m_axis_tuser;    // empty_text

    tf_scoreboard sb;
    int           idle_cycles = 0;
    int           bytes_sent;

    hashed_term_frequency_vector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // gap length: mostly zero or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic last, input bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit allow_gap);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1, allow_gap);
    endtask

    // random byte biased toward letters and digits so tokens form
    function automatic logic [7:0] rand_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'($urandom_range(97, 122));
        if (r < 55) return 8'($urandom_range(65, 90));
        if (r < 65) return 8'($urandom_range(48, 57));
        if (r < 85) return 8'd32;
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver: random stalls with runs of full acceptance
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // sample the output on each accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_entry('{bucket_index: m_axis_tdata[5:0], weight: m_axis_tdata[20:6],
                             last_entry: m_axis_tlast, empty_text: m_axis_tuser});
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int len;
        sb = new();
        bytes_sent = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty text, separator-only text, single tokens, case folding
        send_byte(8'd0, 1'b1, 1'b0);                  // lone separator flagged last
        send_byte(8'hff, 1'b0, 1'b0);                 // high bytes are separators
        send_byte(8'h80, 1'b1, 1'b0);
        send_text("Z", 1'b0);                         // last byte is alphanumeric
        send_text("aA 09 z,", 1'b0);                  // mixed case in one token, digits, trailing separator
        send_text("hello WORLD Hello", 1'b1);
        send_byte(8'h7f, 1'b1, 1'b0);                 // empty after a full text

        // random texts, mostly short, a few long enough to fill many buckets
        while (bytes_sent < 295) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                              : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
                send_byte(rand_text_byte(), i == len - 1, 1'b1);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d bytes in %0d texts, %0d entries checked (%0d empty texts)",
                 bytes_sent, sb.texts_done, sb.entries_seen, sb.empty_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d entries outstanding", sb.mismatches,
                     sb.pending.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
